// File: rtl/mrr_pkg.sv
// shared constants, codes and control structs for the matrix ring rotation block
package mrr_pkg;

  // matrix geometry
  localparam int MAX_N   = 16;
  localparam int IDX_W   = $clog2(MAX_N);
  localparam int N_W     = IDX_W + 1;
  localparam int RING_W  = IDX_W + 2;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_N * MAX_N;

  // data and configuration widths
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'b1;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // reset values
  localparam logic [N_W-1:0]    SIZE_RST  = N_W'(MAX_N);
  localparam logic [STEP_W-1:0] STEPS_RST = '0;

  // modulo unit request
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [RING_W-1:0] divisor;
  } mod_req_t;

  // modulo unit response
  typedef struct packed {
    logic              done;
    logic [RING_W-1:0] rem;
  } mod_rsp_t;

endpackage

// File: rtl/mrr_mod_unit.sv
// iterative remainder unit, two dividend bits per cycle
module mrr_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  mrr_pkg::mod_req_t req,
  output mrr_pkg::mod_rsp_t rsp
);

  localparam int ITER   = mrr_pkg::STEP_W / 2;
  localparam int CNT_W  = $clog2(ITER);
  localparam int RING_W = mrr_pkg::RING_W;
  localparam int STEP_W = mrr_pkg::STEP_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0] shift_r, shift_nxt;
  logic [RING_W-1:0] rem_r, rem_nxt;
  logic [RING_W-1:0] div_r, div_nxt;
  logic [RING_W:0]   t1, t2;
  logic [RING_W-1:0] r1, r2;

  // two restoring compare and subtract steps
  always_comb begin
    t1 = {rem_r, shift_r[STEP_W-1]};
    if (t1 >= {1'b0, div_r}) begin
      r1 = RING_W'(t1 - {1'b0, div_r});
    end else begin
      r1 = t1[RING_W-1:0];
    end
    t2 = {r1, shift_r[STEP_W-2]};
    if (t2 >= {1'b0, div_r}) begin
      r2 = RING_W'(t2 - {1'b0, div_r});
    end else begin
      r2 = t2[RING_W-1:0];
    end
  end

  // sequencing of the iterations
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = req.dividend;
      rem_nxt   = '0;
      div_nxt   = req.divisor;
    end else if (busy_r) begin
      shift_nxt = {shift_r[STEP_W-3:0], 2'b00};
      rem_nxt   = r2;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/mrr_store.sv
// element store, one write and one registered read port
module mrr_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mrr_pkg::ADDR_W-1:0]        waddr,
  input  logic signed [mrr_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [mrr_pkg::ADDR_W-1:0]        raddr,
  output logic signed [mrr_pkg::DATA_W-1:0] rdata
);

  logic signed [mrr_pkg::DATA_W-1:0] mem [mrr_pkg::DEPTH];
  logic signed [mrr_pkg::DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/matrix_ring_rotation.sv
// top level: ring rotation read sequencer, configuration registers and result register
// a write does not leave the idle state, so the input can take another item in the next cycle
// a read inside the size passes through geometry, the remainder unit (iterations and done),
// source lookup and store read; a read on a center element skips the remainder unit and
// source lookup, and a read outside the size goes straight to the final state
// one item at a time; a finished result waits in the output register
// synchronous reset: size 16, rotate steps 0, store contents kept undefined
module matrix_ring_rotation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mrr_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [mrr_pkg::IDX_W-1:0]            in_row,
  input  logic [mrr_pkg::IDX_W-1:0]            in_col,
  input  logic signed [mrr_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mrr_pkg::DATA_W-1:0]    out_value_res,
  output logic                                 out_out_of_range
);

  localparam int IDX_W  = mrr_pkg::IDX_W;
  localparam int N_W    = mrr_pkg::N_W;
  localparam int RING_W = mrr_pkg::RING_W;
  localparam int DATA_W = mrr_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_MOD,
    ST_MAP,
    ST_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [N_W-1:0]           size_r, size_nxt;
  logic [mrr_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]         row_r, row_nxt;
  logic [IDX_W-1:0]         col_r, col_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic                     oor_r, oor_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         edge_r, edge_nxt;
  logic [IDX_W-1:0]         len_r, len_nxt;
  logic [RING_W-1:0]        pos_r, pos_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_oor_r, out_oor_nxt;

  logic                     in_xfer;
  logic                     out_xfer;
  logic [N_W-1:0]           n_eff;
  logic [N_W-1:0]           nm1;
  logic [IDX_W-1:0]         rr, cc, kmin1, kmin2, k_c, edge_c, len_c;
  logic [RING_W-1:0]        pos_c;
  logic [RING_W-1:0]        ring, len2, len3;
  logic [RING_W:0]          s0;
  logic [RING_W-1:0]        s;
  logic [IDX_W-1:0]         src_row, src_col;
  logic                     mem_we, mem_re;
  logic [mrr_pkg::ADDR_W-1:0] mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  mrr_pkg::mod_req_t        mod_req;
  mrr_pkg::mod_rsp_t        mod_rsp;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // effective side length saturates at the store side length
  assign n_eff = (size_r > N_W'(mrr_pkg::MAX_N)) ? N_W'(mrr_pkg::MAX_N) : size_r;

  // ring index, ring bounds and position along the ring
  always_comb begin
    nm1    = n_r - 1'b1;
    rr     = IDX_W'(nm1 - {1'b0, row_r});
    cc     = IDX_W'(nm1 - {1'b0, col_r});
    kmin1  = (row_r < col_r) ? row_r : col_r;
    kmin2  = (rr < cc) ? rr : cc;
    k_c    = (kmin1 < kmin2) ? kmin1 : kmin2;
    edge_c = IDX_W'(nm1[IDX_W-1:0] - k_c);
    len_c  = edge_c - k_c;
    if (row_r == k_c && col_r < edge_c) begin
      pos_c = RING_W'(col_r - k_c);
    end else if (col_r == edge_c && row_r < edge_c) begin
      pos_c = RING_W'(len_c) + RING_W'(row_r - k_c);
    end else if (row_r == edge_c && col_r > k_c) begin
      pos_c = {1'b0, len_c, 1'b0} + RING_W'(edge_c - col_r);
    end else begin
      pos_c = {1'b0, len_c, 1'b0} + RING_W'(len_c) + RING_W'(edge_c - row_r);
    end
  end

  // source position and its row and column
  always_comb begin
    ring = {len_r, 2'b00};
    len2 = {1'b0, len_r, 1'b0};
    len3 = len2 + RING_W'(len_r);
    s0   = {1'b0, pos_r} + {1'b0, ring} - {1'b0, mod_rsp.rem};
    if (s0 >= {1'b0, ring}) begin
      s = RING_W'(s0 - {1'b0, ring});
    end else begin
      s = s0[RING_W-1:0];
    end
    if (s < RING_W'(len_r)) begin
      src_row = k_r;
      src_col = k_r + s[IDX_W-1:0];
    end else if (s < len2) begin
      src_row = k_r + IDX_W'(s - RING_W'(len_r));
      src_col = edge_r;
    end else if (s < len3) begin
      src_row = edge_r;
      src_col = edge_r - IDX_W'(s - len2);
    end else begin
      src_row = edge_r - IDX_W'(s - len3);
      src_col = k_r;
    end
  end

  // store port control
  assign mem_we = in_xfer && (in_command == mrr_pkg::CMD_WRITE);
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {src_row, src_col};
    case (state_r)
      ST_GEOM: begin
        mem_re    = (len_c == '0);
        mem_raddr = {row_r, col_r};
      end
      ST_MAP: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // remainder request
  assign mod_req.start    = (state_r == ST_GEOM) && (len_c != '0);
  assign mod_req.dividend = steps_r;
  assign mod_req.divisor  = {len_c, 2'b00};

  // sequencer and configuration next state
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    steps_nxt     = steps_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    n_nxt         = n_r;
    oor_nxt       = oor_r;
    k_nxt         = k_r;
    edge_nxt      = edge_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;

    if (cfg_we) begin
      case (cfg_index)
        mrr_pkg::REG_SIZE:  size_nxt  = cfg_wdata[N_W-1:0];
        mrr_pkg::REG_STEPS: steps_nxt = cfg_wdata[mrr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_command == mrr_pkg::CMD_READ) begin
          row_nxt   = in_row;
          col_nxt   = in_col;
          n_nxt     = n_eff;
          oor_nxt   = ({1'b0, in_row} >= n_eff) || ({1'b0, in_col} >= n_eff);
          state_nxt = oor_nxt ? ST_DONE : ST_GEOM;
        end
      end
      ST_GEOM: begin
        k_nxt     = k_c;
        edge_nxt  = edge_c;
        len_nxt   = len_c;
        pos_nxt   = pos_c;
        state_nxt = (len_c == '0) ? ST_DONE : ST_MOD;
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = oor_r ? '0 : mem_rdata;
          out_oor_nxt   = oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= mrr_pkg::SIZE_RST;
      steps_r     <= mrr_pkg::STEPS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    n_r         <= n_nxt;
    oor_r       <= oor_nxt;
    k_r         <= k_nxt;
    edge_r      <= edge_nxt;
    len_r       <= len_nxt;
    pos_r       <= pos_nxt;
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value_res    = out_value_r;
  assign out_out_of_range = out_oor_r;

  mrr_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  mrr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({in_row, in_col}),
    .wdata (in_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // out of range results carry zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_value_res == '0)
    else $error("out of range result with nonzero value");

  // remainder completes only while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> state_r == ST_MOD)
    else $error("remainder done outside wait state");

  // a new result comes only from the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside final state");

  // no input transfer while the remainder is computed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> in_stall)
    else $error("input accepted during remainder");

endmodule
